### hdl/scsi_cdb_pkg.sv
`default_nettype none

package scsi_cdb_pkg;

   localparam int unsigned OPCODE_W   = 8;
   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned PRIOR_W    = 31;
   localparam int unsigned CDB_LEN_W  = 5;
   localparam int unsigned XFER_W     = 48;
   localparam int unsigned DIR_W      = 2;
   localparam int unsigned COUNT_W    = 32;
   localparam int unsigned BLK_SIZE_W = 16;

   localparam int unsigned REQ_DATA_W = 80;
   localparam int unsigned RSP_DATA_W = 56;

   localparam logic [BLK_SIZE_W-1:0] BLK_SIZE_RESET = 16'd512;

   localparam logic [OPCODE_W-1:0] OP_WRITE6  = 8'h0a;
   localparam logic [OPCODE_W-1:0] OP_WRITE10 = 8'h2a;
   localparam logic [OPCODE_W-1:0] OP_WRITE12 = 8'haa;

   localparam logic [OPCODE_W-1:0] OP_TEST_UNIT_READY = 8'h00;
   localparam logic [OPCODE_W-1:0] OP_REQUEST_SENSE   = 8'h03;
   localparam logic [OPCODE_W-1:0] OP_READ6           = 8'h08;
   localparam logic [OPCODE_W-1:0] OP_INQUIRY         = 8'h12;
   localparam logic [OPCODE_W-1:0] OP_MODE_SELECT6    = 8'h15;
   localparam logic [OPCODE_W-1:0] OP_MODE_SENSE6     = 8'h1a;
   localparam logic [OPCODE_W-1:0] OP_START_STOP      = 8'h1b;
   localparam logic [OPCODE_W-1:0] OP_PREVENT_ALLOW   = 8'h1e;
   localparam logic [OPCODE_W-1:0] OP_READ_CAPACITY   = 8'h25;
   localparam logic [OPCODE_W-1:0] OP_READ10          = 8'h28;
   localparam logic [OPCODE_W-1:0] OP_VERIFY10        = 8'h2f;
   localparam logic [OPCODE_W-1:0] OP_SYNC_CACHE      = 8'h35;
   localparam logic [OPCODE_W-1:0] OP_READ_DEFECT     = 8'h37;
   localparam logic [OPCODE_W-1:0] OP_READ_SUBCHANNEL = 8'h42;
   localparam logic [OPCODE_W-1:0] OP_READ_TOC        = 8'h43;
   localparam logic [OPCODE_W-1:0] OP_READ_DISC_INFO  = 8'h51;
   localparam logic [OPCODE_W-1:0] OP_READ_TRACK_INFO = 8'h52;
   localparam logic [OPCODE_W-1:0] OP_MODE_SELECT10   = 8'h55;
   localparam logic [OPCODE_W-1:0] OP_MODE_SENSE10    = 8'h5a;
   localparam logic [OPCODE_W-1:0] OP_READ12          = 8'ha8;

   typedef enum logic [DIR_W-1:0] {
      DIR_NONE = 2'd0,
      DIR_OUT  = 2'd1,
      DIR_IN   = 2'd2
   } dir_type;

   typedef logic [CDB_LEN_W-1:0] cdb_len_type;

   // CDB length by opcode group, opcode bits 7..5
   localparam cdb_len_type GROUP_LEN [8] = '{
      5'd6, 5'd10, 5'd10, 5'd12, 5'd16, 5'd12, 5'd10, 5'd10
   };

   typedef struct packed {
      cdb_len_type         cdb_length;
      dir_type             direction;
      logic                unknown_opcode;
      logic                is_write;
      logic [COUNT_W-1:0]  block_count;
   } decode_type;

endpackage

`default_nettype wire

### hdl/scsi_cdb_analyzer.sv
// An item accepted on req is captured in the input register, and its decode
// is loaded into the result register that drives rsp once that is free.
// Throughput: one item per cycle while rsp_tready is not held low; the
// input register, decode plus the 32x16 multiply, and the result register
// form a two-stage pipeline. Reset (synchronous, active high) empties
// both stages and sets the block size register to 512.
`default_nettype none

module scsi_cdb_analyzer (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    csr_wr_en,
   input  wire logic [scsi_cdb_pkg::BLK_SIZE_W-1:0]     csr_wr_data,
   input  wire logic                                    req_tvalid,
   output      logic                                    req_tready,
   // opcode, cdb_byte4, cdb_byte6, cdb_byte7, cdb_byte8, cdb_byte9,
   // prior_length, zero pad
   input  wire logic [scsi_cdb_pkg::REQ_DATA_W-1:0]     req_tdata,
   output      logic                                    rsp_tvalid,
   input  wire logic                                    rsp_tready,
   // cdb_length, transfer_length, direction, unknown_opcode
   output      logic [scsi_cdb_pkg::RSP_DATA_W-1:0]     rsp_tdata
);

   logic [scsi_cdb_pkg::BLK_SIZE_W-1:0] blk_size_ff;

   logic                                 s1_valid_ff;
   logic                                 s1_valid_in;
   logic [scsi_cdb_pkg::REQ_DATA_W-1:0]  s1_data_ff;

   logic                                 rsp_valid_ff;
   logic                                 rsp_valid_in;
   logic [scsi_cdb_pkg::RSP_DATA_W-1:0]  rsp_data_ff;
   logic [scsi_cdb_pkg::RSP_DATA_W-1:0]  rsp_data_in;

   logic                                 req_accept;
   logic                                 rsp_free;
   logic                                 s2_load;

   scsi_cdb_pkg::decode_type             decode;
   logic [scsi_cdb_pkg::XFER_W-1:0]      product;
   logic [scsi_cdb_pkg::XFER_W-1:0]      xfer_len;

   always_ff @(posedge clock) begin
      if (reset) begin
         blk_size_ff <= scsi_cdb_pkg::BLK_SIZE_RESET;
      end else if (csr_wr_en) begin
         blk_size_ff <= csr_wr_data;
      end
   end

   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign s2_load    = s1_valid_ff && rsp_free;
   assign req_tready = !s1_valid_ff || rsp_free;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (rsp_free) begin
         s1_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (s2_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_data_ff <= req_tdata;
      end
      if (s2_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   scsi_cdb_decode u_decode (
      .opcode    (s1_data_ff[7:0]),
      .cdb_byte4 (s1_data_ff[15:8]),
      .cdb_byte6 (s1_data_ff[23:16]),
      .cdb_byte7 (s1_data_ff[31:24]),
      .cdb_byte8 (s1_data_ff[39:32]),
      .cdb_byte9 (s1_data_ff[47:40]),
      .decode    (decode)
   );

   // 32-bit count times 16-bit block size fits 48 bits exactly
   assign product = {16'd0, decode.block_count} * {32'd0, blk_size_ff};

   assign xfer_len = decode.is_write ? product : {17'd0, s1_data_ff[78:48]};

   assign rsp_data_in = {decode.unknown_opcode, decode.direction, xfer_len,
                         decode.cdb_length};

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

### hdl/scsi_cdb_decode.sv
`default_nettype none

module scsi_cdb_decode (
   input  wire logic [scsi_cdb_pkg::OPCODE_W-1:0] opcode,
   input  wire logic [scsi_cdb_pkg::BYTE_W-1:0]   cdb_byte4,
   input  wire logic [scsi_cdb_pkg::BYTE_W-1:0]   cdb_byte6,
   input  wire logic [scsi_cdb_pkg::BYTE_W-1:0]   cdb_byte7,
   input  wire logic [scsi_cdb_pkg::BYTE_W-1:0]   cdb_byte8,
   input  wire logic [scsi_cdb_pkg::BYTE_W-1:0]   cdb_byte9,
   output scsi_cdb_pkg::decode_type               decode
);

   always_comb begin
      decode.cdb_length     = scsi_cdb_pkg::GROUP_LEN[opcode[7:5]];
      decode.direction      = scsi_cdb_pkg::DIR_NONE;
      decode.unknown_opcode = 1'b0;
      decode.is_write       = 1'b0;
      decode.block_count    = '0;

      case (opcode)
         scsi_cdb_pkg::OP_WRITE6, scsi_cdb_pkg::OP_WRITE10,
         scsi_cdb_pkg::OP_VERIFY10, scsi_cdb_pkg::OP_WRITE12,
         scsi_cdb_pkg::OP_MODE_SELECT6, scsi_cdb_pkg::OP_MODE_SELECT10: begin
            decode.direction = scsi_cdb_pkg::DIR_OUT;
         end
         scsi_cdb_pkg::OP_REQUEST_SENSE, scsi_cdb_pkg::OP_READ6,
         scsi_cdb_pkg::OP_INQUIRY, scsi_cdb_pkg::OP_MODE_SENSE6,
         scsi_cdb_pkg::OP_MODE_SENSE10, scsi_cdb_pkg::OP_READ_CAPACITY,
         scsi_cdb_pkg::OP_READ10, scsi_cdb_pkg::OP_READ_DEFECT,
         scsi_cdb_pkg::OP_READ_SUBCHANNEL, scsi_cdb_pkg::OP_READ_TOC,
         scsi_cdb_pkg::OP_READ12, scsi_cdb_pkg::OP_READ_DISC_INFO,
         scsi_cdb_pkg::OP_READ_TRACK_INFO: begin
            decode.direction = scsi_cdb_pkg::DIR_IN;
         end
         scsi_cdb_pkg::OP_TEST_UNIT_READY, scsi_cdb_pkg::OP_START_STOP,
         scsi_cdb_pkg::OP_PREVENT_ALLOW, scsi_cdb_pkg::OP_SYNC_CACHE: begin
            decode.direction = scsi_cdb_pkg::DIR_NONE;
         end
         default: begin
            decode.unknown_opcode = 1'b1;
         end
      endcase

      // pick the block count out of the CDB; a zero six-byte count stays zero
      case (opcode)
         scsi_cdb_pkg::OP_WRITE6: begin
            decode.is_write    = 1'b1;
            decode.block_count = {24'd0, cdb_byte4};
         end
         scsi_cdb_pkg::OP_WRITE10: begin
            decode.is_write    = 1'b1;
            decode.block_count = {16'd0, cdb_byte7, cdb_byte8};
         end
         scsi_cdb_pkg::OP_WRITE12: begin
            decode.is_write    = 1'b1;
            decode.block_count = {cdb_byte6, cdb_byte7, cdb_byte8, cdb_byte9};
         end
         default: begin
            decode.is_write    = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

### bench/tb_scsi_cdb_analyzer.sv
`default_nettype none

module tb_scsi_cdb_analyzer;
   timeunit 1ns;
   timeprecision 1ps;

   // Not in any list: used as known unknown opcodes
   localparam logic [scsi_cdb_pkg::OPCODE_W-1:0] OP_VENDOR_LOW  = 8'h01;
   localparam logic [scsi_cdb_pkg::OPCODE_W-1:0] OP_VENDOR_HIGH = 8'hff;

   localparam int unsigned N_OUT_OPS  = 6;
   localparam int unsigned N_IN_OPS   = 13;
   localparam int unsigned N_NONE_OPS = 4;

   localparam logic [scsi_cdb_pkg::OPCODE_W-1:0] OUT_OPS [N_OUT_OPS] = '{
      scsi_cdb_pkg::OP_WRITE6, scsi_cdb_pkg::OP_WRITE10, scsi_cdb_pkg::OP_VERIFY10,
      scsi_cdb_pkg::OP_WRITE12, scsi_cdb_pkg::OP_MODE_SELECT6,
      scsi_cdb_pkg::OP_MODE_SELECT10
   };
   localparam logic [scsi_cdb_pkg::OPCODE_W-1:0] IN_OPS [N_IN_OPS] = '{
      scsi_cdb_pkg::OP_REQUEST_SENSE, scsi_cdb_pkg::OP_READ6, scsi_cdb_pkg::OP_INQUIRY,
      scsi_cdb_pkg::OP_MODE_SENSE6, scsi_cdb_pkg::OP_MODE_SENSE10,
      scsi_cdb_pkg::OP_READ_CAPACITY, scsi_cdb_pkg::OP_READ10,
      scsi_cdb_pkg::OP_READ_DEFECT, scsi_cdb_pkg::OP_READ_SUBCHANNEL,
      scsi_cdb_pkg::OP_READ_TOC, scsi_cdb_pkg::OP_READ12,
      scsi_cdb_pkg::OP_READ_DISC_INFO, scsi_cdb_pkg::OP_READ_TRACK_INFO
   };
   localparam logic [scsi_cdb_pkg::OPCODE_W-1:0] NONE_OPS [N_NONE_OPS] = '{
      scsi_cdb_pkg::OP_TEST_UNIT_READY, scsi_cdb_pkg::OP_START_STOP,
      scsi_cdb_pkg::OP_PREVENT_ALLOW, scsi_cdb_pkg::OP_SYNC_CACHE
   };
   localparam logic [scsi_cdb_pkg::OPCODE_W-1:0] WRITE_OPS [3] = '{
      scsi_cdb_pkg::OP_WRITE6, scsi_cdb_pkg::OP_WRITE10, scsi_cdb_pkg::OP_WRITE12
   };

   localparam scsi_cdb_pkg::cdb_len_type CDB_BYTES_BY_GROUP [8] = '{
      5'd6, 5'd10, 5'd10, 5'd12, 5'd16, 5'd12, 5'd10, 5'd10
   };

   // prior_length starts above the six CDB bytes; the request bus carries
   // only as many of its bits as fit below its top
   localparam int unsigned PRIOR_LSB = 6 * scsi_cdb_pkg::BYTE_W;
   localparam int unsigned PRIOR_CARRIED =
      (scsi_cdb_pkg::REQ_DATA_W - PRIOR_LSB < scsi_cdb_pkg::PRIOR_W) ?
      scsi_cdb_pkg::REQ_DATA_W - PRIOR_LSB : scsi_cdb_pkg::PRIOR_W;
   localparam logic [scsi_cdb_pkg::PRIOR_W-1:0] PRIOR_MASK =
      scsi_cdb_pkg::PRIOR_W'((64'd1 << PRIOR_CARRIED) - 64'd1);

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_HALF,
      STALL_HEAVY,
      STALL_PERIODIC
   } stall_mode_type;

   typedef struct {
      logic [scsi_cdb_pkg::OPCODE_W-1:0] opcode;
      logic [scsi_cdb_pkg::BYTE_W-1:0]   byte4;
      logic [scsi_cdb_pkg::BYTE_W-1:0]   byte6;
      logic [scsi_cdb_pkg::BYTE_W-1:0]   byte7;
      logic [scsi_cdb_pkg::BYTE_W-1:0]   byte8;
      logic [scsi_cdb_pkg::BYTE_W-1:0]   byte9;
      logic [scsi_cdb_pkg::PRIOR_W-1:0]  prior_length;
   } cdb_command_type;

   typedef struct {
      scsi_cdb_pkg::cdb_len_type         cdb_length;
      logic [scsi_cdb_pkg::XFER_W-1:0]   transfer_length;
      scsi_cdb_pkg::dir_type             direction;
      logic                              unknown_opcode;
   } cdb_decode_type;

   class cdb_scoreboard;
      logic [scsi_cdb_pkg::BLK_SIZE_W-1:0] block_size;
      cdb_decode_type        decode_q[$];
      int unsigned           commands;
      int unsigned           writes;
      int unsigned           unknowns;
      int unsigned           decodes_checked;
      int unsigned           failures;

      function new();
         block_size      = scsi_cdb_pkg::BLK_SIZE_RESET;
         commands        = 0;
         writes          = 0;
         unknowns        = 0;
         decodes_checked = 0;
         failures        = 0;
      endfunction

      function void set_block_size(input logic [scsi_cdb_pkg::BLK_SIZE_W-1:0] value);
         block_size = value;
      endfunction

      function cdb_decode_type decode_command(input cdb_command_type c);
         cdb_decode_type                   d;
         logic [scsi_cdb_pkg::COUNT_W-1:0] count;
         logic                             is_write;
         count    = '0;
         is_write = 1'b1;
         case (c.opcode)
            scsi_cdb_pkg::OP_WRITE6: begin
               count = {24'd0, c.byte4};
            end
            scsi_cdb_pkg::OP_WRITE10: begin
               count = {16'd0, c.byte7, c.byte8};
            end
            scsi_cdb_pkg::OP_WRITE12: begin
               count = {c.byte6, c.byte7, c.byte8, c.byte9};
            end
            default: begin
               is_write = 1'b0;
            end
         endcase
         d.cdb_length      = CDB_BYTES_BY_GROUP[c.opcode[7:5]];
         d.transfer_length = is_write ?
            scsi_cdb_pkg::XFER_W'(count) * scsi_cdb_pkg::XFER_W'(block_size) :
            scsi_cdb_pkg::XFER_W'(c.prior_length);
         d.direction       = scsi_cdb_pkg::DIR_NONE;
         d.unknown_opcode  = 1'b1;
         foreach (NONE_OPS[i]) if (NONE_OPS[i] == c.opcode) d.unknown_opcode = 1'b0;
         foreach (IN_OPS[i]) begin
            if (IN_OPS[i] == c.opcode) begin
               d.direction      = scsi_cdb_pkg::DIR_IN;
               d.unknown_opcode = 1'b0;
            end
         end
         // out list wins over the others
         foreach (OUT_OPS[i]) begin
            if (OUT_OPS[i] == c.opcode) begin
               d.direction      = scsi_cdb_pkg::DIR_OUT;
               d.unknown_opcode = 1'b0;
            end
         end
         return d;
      endfunction

      function void note_command(input cdb_command_type c);
         cdb_decode_type d;
         d = decode_command(c);
         decode_q.push_back(d);
         commands++;
         if (c.opcode == scsi_cdb_pkg::OP_WRITE6 || c.opcode == scsi_cdb_pkg::OP_WRITE10 ||
             c.opcode == scsi_cdb_pkg::OP_WRITE12)
            writes++;
         if (d.unknown_opcode)
            unknowns++;
      endfunction

      function void check_result(input logic [scsi_cdb_pkg::RSP_DATA_W-1:0] bits);
         cdb_decode_type want;
         cdb_decode_type got;
         got.cdb_length      = bits[4:0];
         got.transfer_length = bits[52:5];
         got.direction       = scsi_cdb_pkg::dir_type'(bits[54:53]);
         got.unknown_opcode  = bits[55];
         if (decode_q.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("ERROR: result with no command pending: data %h", bits);
            return;
         end
         want = decode_q.pop_front();
         decodes_checked++;
         if (got.cdb_length != want.cdb_length ||
             got.transfer_length != want.transfer_length ||
             got.direction != want.direction ||
             got.unknown_opcode != want.unknown_opcode) begin
            failures++;
            if (failures <= 10) begin
               $display("ERROR: result %0d: cdb_length %0d/%0d, transfer_length %0d/%0d,",
                        decodes_checked, want.cdb_length, got.cdb_length,
                        want.transfer_length, got.transfer_length);
               $display("  direction %0d/%0d, unknown_opcode %0d/%0d (expected/actual)",
                        want.direction, got.direction,
                        want.unknown_opcode, got.unknown_opcode);
            end
         end
      endfunction

      function int unsigned pending();
         return decode_q.size();
      endfunction
   endclass

   logic                                     clock;
   logic                                     reset;
   logic                                     csr_wr_en;
   logic [scsi_cdb_pkg::BLK_SIZE_W-1:0]      csr_wr_data;
   logic                                     req_tvalid;
   logic                                     req_tready;
   // opcode, cdb_byte4, cdb_byte6, cdb_byte7, cdb_byte8, cdb_byte9, prior_length, zero pad
   logic [scsi_cdb_pkg::REQ_DATA_W-1:0]      req_tdata;
   logic                                     rsp_tvalid;
   logic                                     rsp_tready;
   // cdb_length, transfer_length, direction, unknown_opcode
   logic [scsi_cdb_pkg::RSP_DATA_W-1:0]      rsp_tdata;

   cdb_scoreboard sb;
   int unsigned   sizes_used;

   scsi_cdb_analyzer uut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #3ms;
      $display("Test completed with failures");
      $finish;
   end

   // Receiver: switch between randomly chosen stall patterns, each held for a random span
   initial begin
      stall_mode_type mode;
      int unsigned    span;
      int unsigned    tick;
      rsp_tready = 1'b0;
      tick       = 0;
      forever begin
         mode = stall_mode_type'($urandom_range(0, 3));
         span = $urandom_range(20, 80);
         repeat (span) begin
            @(negedge clock);
            tick++;
            case (mode)
               STALL_NONE:     rsp_tready <= 1'b1;
               STALL_HALF:     rsp_tready <= 1'($urandom_range(0, 1));
               STALL_HEAVY:    rsp_tready <= ($urandom_range(0, 3) == 0);
               STALL_PERIODIC: rsp_tready <= (tick % 5 == 0);
               default:        rsp_tready <= 1'b1;
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result(rsp_tdata);
   end

   function automatic logic [scsi_cdb_pkg::REQ_DATA_W-1:0] pack_command(
      input cdb_command_type c);
      logic [scsi_cdb_pkg::REQ_DATA_W-1:0] bits;
      bits        = '0;
      bits[7:0]   = c.opcode;
      bits[15:8]  = c.byte4;
      bits[23:16] = c.byte6;
      bits[31:24] = c.byte7;
      bits[39:32] = c.byte8;
      bits[47:40] = c.byte9;
      for (int k = 0; k < PRIOR_CARRIED; k++)
         bits[PRIOR_LSB + k] = c.prior_length[k];
      return bits;
   endfunction

   function automatic logic [scsi_cdb_pkg::BYTE_W-1:0] count_byte();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         default: return scsi_cdb_pkg::BYTE_W'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic cdb_command_type random_command();
      cdb_command_type c;
      int unsigned     pick;
      pick = $urandom_range(0, 9);
      if (pick < 4)
         c.opcode = WRITE_OPS[$urandom_range(0, 2)];
      else if (pick < 7) begin
         case ($urandom_range(0, 2))
            0:       c.opcode = OUT_OPS[$urandom_range(0, N_OUT_OPS - 1)];
            1:       c.opcode = IN_OPS[$urandom_range(0, N_IN_OPS - 1)];
            default: c.opcode = NONE_OPS[$urandom_range(0, N_NONE_OPS - 1)];
         endcase
      end else
         c.opcode = scsi_cdb_pkg::OPCODE_W'($urandom_range(0, 255));
      c.byte4        = count_byte();
      c.byte6        = count_byte();
      c.byte7        = count_byte();
      c.byte8        = count_byte();
      c.byte9        = count_byte();
      c.prior_length = scsi_cdb_pkg::PRIOR_W'($urandom) & PRIOR_MASK;
      return c;
   endfunction

   // Present one item from the next falling edge and hold it until accepted
   task automatic drive_command(input cdb_command_type c);
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= pack_command(c);
      do @(posedge clock); while (!req_tready);
      sb.note_command(c);
   endtask

   task automatic drop_valid();
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_block_size(input logic [scsi_cdb_pkg::BLK_SIZE_W-1:0] value);
      wait_drained();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      sb.set_block_size(value);
      sizes_used++;
   endtask

   task automatic send_random(input int unsigned n, input bit pause_midway);
      int unsigned sent;
      int unsigned burst;
      int unsigned gap;
      sent  = 0;
      burst = $urandom_range(1, 40);
      while (sent < n) begin
         drive_command(random_command());
         sent++;
         burst--;
         if (pause_midway && sent == n / 2) begin
            // hold off until every decode is back
            drop_valid();
            wait_drained();
         end else if (burst == 0) begin
            burst = $urandom_range(1, 40);
            gap   = $urandom_range(0, 6);
            if (gap != 0) begin
               drop_valid();
               repeat (gap - 1) @(negedge clock);
            end
         end
      end
      drop_valid();
   endtask

   task automatic send_directed();
      cdb_command_type c;
      c.byte4        = '1;
      c.byte6        = '1;
      c.byte7        = '1;
      c.byte8        = '1;
      c.byte9        = '1;
      c.prior_length = '1 & PRIOR_MASK;
      foreach (OUT_OPS[i]) begin
         c.opcode = OUT_OPS[i];
         drive_command(c);
      end
      foreach (IN_OPS[i]) begin
         c.opcode = IN_OPS[i];
         drive_command(c);
      end
      c.prior_length = '0;
      foreach (NONE_OPS[i]) begin
         c.opcode = NONE_OPS[i];
         drive_command(c);
      end
      c.opcode = OP_VENDOR_HIGH;
      drive_command(c);
      c.opcode       = OP_VENDOR_LOW;
      c.prior_length = '1 & PRIOR_MASK;
      drive_command(c);
      // six-byte write with zero count gives zero length
      c.opcode = scsi_cdb_pkg::OP_WRITE6;
      c.byte4  = '0;
      drive_command(c);
      c.opcode = scsi_cdb_pkg::OP_WRITE12;
      c.byte6  = '0;
      c.byte7  = '0;
      c.byte8  = '0;
      c.byte9  = '0;
      drive_command(c);
      drop_valid();
   endtask

   initial begin
      sb          = new();
      sizes_used  = 0;
      reset       = 1'b1;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      send_random(40, 1'b0);
      write_block_size(16'hffff);
      send_directed();
      send_random(200, 1'b0);
      write_block_size(16'd1);
      send_random(200, 1'b1);
      write_block_size(16'd0);
      send_random(100, 1'b0);
      repeat (2) begin
         write_block_size(scsi_cdb_pkg::BLK_SIZE_W'($urandom_range(1, 65535)));
         send_random(200, 1'b0);
      end

      wait_drained();
      repeat (10) @(posedge clock);
      $display("Decoded %0d commands (%0d writes, %0d unknown opcodes), %0d results checked",
               sb.commands, sb.writes, sb.unknowns, sb.decodes_checked);
      $display("Block size: reset value plus %0d written settings; %0d failures",
               sizes_used, sb.failures);
      if (sb.failures == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

`default_nettype wire
